### design/y4m_pkg.sv
// Shared types, constants and helper functions of the YUV4MPEG2 header parser.
`default_nettype none

package y4m_pkg;

    localparam int DIM_BITS     = 16;
    localparam int RATE_BITS    = 32;
    localparam int FMT_BITS     = 10;
    localparam int FB_BITS      = 34;
    localparam int PX_BITS      = 2 * DIM_BITS;
    localparam int DIV_CNT_BITS = $clog2(RATE_BITS);
    localparam int MAGIC_LEN    = 9;

    localparam logic [DIM_BITS-1:0]  DIM_MAX  = {DIM_BITS{1'b1}};
    localparam logic [RATE_BITS-1:0] RATE_MAX = {RATE_BITS{1'b1}};
    localparam logic [FMT_BITS-1:0]  FMT_MAX  = {FMT_BITS{1'b1}};

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_W     = "W";
    localparam logic [7:0] CH_H     = "H";
    localparam logic [7:0] CH_F     = "F";
    localparam logic [7:0] CH_I     = "I";
    localparam logic [7:0] CH_C     = "C";
    localparam logic [7:0] CH_P     = "p";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_B     = "b";
    localparam logic [7:0] CH_M     = "m";

    // scan mode codes
    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_PROG    = 3'd1;
    localparam logic [2:0] MODE_TOP     = 3'd2;
    localparam logic [2:0] MODE_BOTTOM  = 3'd3;
    localparam logic [2:0] MODE_MIXED   = 3'd4;
    localparam logic [2:0] MODE_UNKNOWN = 3'd5;

    // chroma format codes
    localparam logic [1:0] FMT_420 = 2'd0;
    localparam logic [1:0] FMT_422 = 2'd1;
    localparam logic [1:0] FMT_444 = 2'd2;
    localparam logic [1:0] FMT_411 = 2'd3;

    // rate token progress
    localparam logic [1:0] RS_NONE  = 2'd0;
    localparam logic [1:0] RS_BEGUN = 2'd1;
    localparam logic [1:0] RS_DEN   = 2'd2;

    typedef enum logic [4:0] {
        PH_MAGIC = 5'b00001,
        PH_SEP   = 5'b00010,
        PH_GAP   = 5'b00100,
        PH_TOKEN = 5'b01000,
        PH_SKIP  = 5'b10000
    } t_phase;

    typedef enum logic [7:0] {
        TK_NONE = 8'b0000_0001,
        TK_W    = 8'b0000_0010,
        TK_H    = 8'b0000_0100,
        TK_FBEG = 8'b0000_1000,
        TK_I    = 8'b0001_0000,
        TK_C    = 8'b0010_0000,
        TK_FNUM = 8'b0100_0000,
        TK_FDEN = 8'b1000_0000
    } t_token;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // header contents handed over when the newline is taken
    typedef struct packed {
        logic                 ok;
        logic [DIM_BITS-1:0]  width;
        logic [DIM_BITS-1:0]  height;
        logic [RATE_BITS-1:0] num;
        logic [RATE_BITS-1:0] den;
        logic                 err;
        logic                 do_div;
        logic [2:0]           mode;
        logic [1:0]           fmt;
    } t_snap;

    typedef struct packed {
        logic load;
        logic div_step;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [7:0] magic_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "Y";
            4'd1:    c = "U";
            4'd2:    c = "V";
            4'd3:    c = "4";
            4'd4:    c = "M";
            4'd5:    c = "P";
            4'd6:    c = "E";
            4'd7:    c = "G";
            4'd8:    c = "2";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [DIM_BITS-1:0] dim_digit(input logic [DIM_BITS-1:0] acc,
                                                       input logic [3:0] d);
        logic [DIM_BITS+3:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{DIM_BITS{1'b0}}, d};
        return (v > {4'b0, DIM_MAX}) ? DIM_MAX : v[DIM_BITS-1:0];
    endfunction

    function automatic logic [RATE_BITS-1:0] rate_digit(input logic [RATE_BITS-1:0] acc,
                                                         input logic [3:0] d);
        logic [RATE_BITS+3:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{RATE_BITS{1'b0}}, d};
        return (v > {4'b0, RATE_MAX}) ? RATE_MAX : v[RATE_BITS-1:0];
    endfunction

    function automatic logic [FMT_BITS-1:0] fmt_digit(input logic [FMT_BITS-1:0] acc,
                                                       input logic [3:0] d);
        logic [FMT_BITS+3:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{FMT_BITS{1'b0}}, d};
        return (v > {4'b0, FMT_MAX}) ? FMT_MAX : v[FMT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### design/y4m_stream_header_parser_unit.sv
// Top level of the YUV4MPEG2 stream header parser.
// Throughput: one header byte per cycle; a newline waits only while a previous
//   header's result is still in the divider or blocked behind the output register.
// Flow: a taken newline loads the job registers, the bit-serial frame-rate division then
//   runs its 32 divider steps, and the result is handed into the output register.
// Reset: synchronous, active low; clears the parse state, the controller and o_valid.
`default_nettype none

module y4m_stream_header_parser_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // header byte channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [7:0]                      i_data_byte,
    input  wire logic                            i_start_req,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_header_ok,
    output logic [y4m_pkg::DIM_BITS-1:0]         o_width,
    output logic [y4m_pkg::DIM_BITS-1:0]         o_height,
    output logic [y4m_pkg::RATE_BITS-1:0]        o_fps,
    output logic                                 o_rate_error,
    output logic [2:0]                           o_scan_mode,
    output logic [1:0]                           o_chroma_format,
    output logic [y4m_pkg::FB_BITS-1:0]          o_frame_bytes
);
    import y4m_pkg::*;

    logic      is_nl;
    logic      accept;
    logic      launch;
    logic      ctrl_idle;
    t_snap     snap;
    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // Ordinary bytes always go straight into the tokeniser. A newline hands the
    // whole header over to the result datapath, so hold it back until the
    // controller is free to take a new job.
    assign is_nl   = (i_data_byte == CH_NL);
    assign o_stall = is_nl && !ctrl_idle;
    assign accept  = i_valid && !o_stall;
    assign launch  = accept && is_nl;

    // Tokeniser: the parse state advances on every accepted item and drops back
    // to its reset state after a newline.
    y4m_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_start_req (i_start_req),
        .o_snap      (snap)
    );

    // Controller: load the job, run the divider, then hand the result over.
    y4m_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_launch (launch),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_idle   (ctrl_idle)
    );

    // Datapath: the job registers free the tokeniser for the next header at once.
    y4m_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_snap          (snap),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_header_ok     (o_header_ok),
        .o_width         (o_width),
        .o_height        (o_height),
        .o_fps           (o_fps),
        .o_rate_error    (o_rate_error),
        .o_scan_mode     (o_scan_mode),
        .o_chroma_format (o_chroma_format),
        .o_frame_bytes   (o_frame_bytes)
    );

    a_nl_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch |-> ctrl_idle)
        else $error("newline taken while a job is running");

    a_plain_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_nl |-> !o_stall)
        else $error("ordinary byte held back");

    a_launch_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch |-> cmd.load)
        else $error("accepted newline did not start a job");

endmodule

`default_nettype wire

### design/y4m_parse.sv
// Byte-level header tokeniser: magic check, token split and decimal accumulators.
`default_nettype none

module y4m_parse (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_start_req,
    output y4m_pkg::t_snap      o_snap
);
    import y4m_pkg::*;

    t_phase                r_phase, n_phase, c_phase;
    logic [3:0]            r_midx,  n_midx,  c_midx;
    logic                  r_good,  n_good,  c_good;
    t_token                r_kind,  n_kind,  c_kind;
    logic [DIM_BITS-1:0]   r_w,     n_w,     c_w;
    logic [DIM_BITS-1:0]   r_h,     n_h,     c_h;
    logic [RATE_BITS-1:0]  r_num,   n_num,   c_num;
    logic [RATE_BITS-1:0]  r_den,   n_den,   c_den;
    logic [1:0]            r_rs,    n_rs,    c_rs;
    logic [2:0]            r_mode,  n_mode,  c_mode;
    logic [FMT_BITS-1:0]   r_fnum,  n_fnum,  c_fnum;
    logic [1:0]            r_fmt,   n_fmt,   c_fmt;

    logic                  is_digit;
    logic [3:0]            digit;
    logic                  fmt_hit;
    logic [1:0]            fmt_code;
    logic                  commit_ok;
    logic                  magic_match;

    // start request: work from the reset state
    always_comb begin
        if (i_start_req) begin
            c_phase = PH_MAGIC; c_midx = '0;  c_good = 1'b1; c_kind = TK_NONE;
            c_w     = '0;       c_h    = '0;  c_num  = '0;   c_den  = '0;
            c_rs    = RS_NONE;  c_mode = MODE_NONE; c_fnum = '0; c_fmt = FMT_420;
        end else begin
            c_phase = r_phase;  c_midx = r_midx; c_good = r_good; c_kind = r_kind;
            c_w     = r_w;      c_h    = r_h;    c_num  = r_num;  c_den  = r_den;
            c_rs    = r_rs;     c_mode = r_mode; c_fnum = r_fnum; c_fmt  = r_fmt;
        end
    end

    assign is_digit    = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign digit       = 4'(i_data_byte - CH_ZERO);
    assign magic_match = (i_data_byte == magic_char(c_midx));

    always_comb begin
        fmt_hit  = 1'b1;
        fmt_code = FMT_420;
        unique case (c_fnum)
            FMT_BITS'(420): fmt_code = FMT_420;
            FMT_BITS'(422): fmt_code = FMT_422;
            FMT_BITS'(444): fmt_code = FMT_444;
            FMT_BITS'(411): fmt_code = FMT_411;
            default:        fmt_hit  = 1'b0;
        endcase
    end

    // a C token in progress ends here: take its value if it names a format
    assign commit_ok = (c_kind == TK_C) && fmt_hit;

    always_comb begin
        n_phase = c_phase; n_midx = c_midx; n_good = c_good; n_kind = c_kind;
        n_w     = c_w;     n_h    = c_h;    n_num  = c_num;  n_den  = c_den;
        n_rs    = c_rs;    n_mode = c_mode; n_fnum = c_fnum; n_fmt  = c_fmt;
        if (i_data_byte == CH_NL) begin
            n_phase = PH_MAGIC; n_midx = '0;  n_good = 1'b1; n_kind = TK_NONE;
            n_w     = '0;       n_h    = '0;  n_num  = '0;   n_den  = '0;
            n_rs    = RS_NONE;  n_mode = MODE_NONE; n_fnum = '0; n_fmt = FMT_420;
        end else begin
            unique case (c_phase)
                PH_MAGIC: begin
                    n_good = c_good & magic_match;
                    n_midx = c_midx + 4'd1;
                    if (c_midx == 4'(MAGIC_LEN - 1)) begin
                        n_phase = (c_good & magic_match) ? PH_SEP : PH_SKIP;
                    end
                end
                PH_SEP: begin
                    n_phase = PH_GAP;
                end
                PH_GAP: begin
                    if (i_data_byte != CH_SPACE) begin
                        n_phase = PH_TOKEN;
                        unique case (i_data_byte)
                            CH_W: begin n_w = '0; n_kind = TK_W; end
                            CH_H: begin n_h = '0; n_kind = TK_H; end
                            CH_F: begin
                                n_num = '0; n_den = '0; n_rs = RS_BEGUN; n_kind = TK_FBEG;
                            end
                            CH_I: begin n_mode = MODE_UNKNOWN; n_kind = TK_I; end
                            CH_C: begin n_fnum = '0; n_kind = TK_C; end
                            default: n_kind = TK_NONE;
                        endcase
                    end
                end
                PH_TOKEN: begin
                    if (i_data_byte == CH_SPACE) begin
                        if (commit_ok) n_fmt = fmt_code;
                        n_kind  = TK_NONE;
                        n_phase = PH_GAP;
                    end else begin
                        unique case (c_kind)
                            TK_W: begin
                                if (is_digit) n_w = dim_digit(c_w, digit);
                                else          n_kind = TK_NONE;
                            end
                            TK_H: begin
                                if (is_digit) n_h = dim_digit(c_h, digit);
                                else          n_kind = TK_NONE;
                            end
                            TK_FBEG: begin
                                if (is_digit) begin
                                    n_num  = {{(RATE_BITS-4){1'b0}}, digit};
                                    n_kind = TK_FNUM;
                                end else begin
                                    n_kind = TK_NONE;
                                end
                            end
                            TK_FNUM: begin
                                if (is_digit)                      n_num  = rate_digit(c_num, digit);
                                else if (i_data_byte == CH_COLON)  n_kind = TK_FDEN;
                                else                               n_kind = TK_NONE;
                            end
                            TK_FDEN: begin
                                if (is_digit) begin
                                    n_den = rate_digit(c_den, digit);
                                    n_rs  = RS_DEN;
                                end else begin
                                    n_kind = TK_NONE;
                                end
                            end
                            TK_I: begin
                                unique case (i_data_byte)
                                    CH_P:    n_mode = MODE_PROG;
                                    CH_T:    n_mode = MODE_TOP;
                                    CH_B:    n_mode = MODE_BOTTOM;
                                    CH_M:    n_mode = MODE_MIXED;
                                    default: n_mode = MODE_UNKNOWN;
                                endcase
                                n_kind = TK_NONE;
                            end
                            TK_C: begin
                                if (is_digit) begin
                                    n_fnum = fmt_digit(c_fnum, digit);
                                end else begin
                                    if (commit_ok) n_fmt = fmt_code;
                                    n_kind = TK_NONE;
                                end
                            end
                            TK_NONE: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                PH_SKIP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_midx <= '0;  r_good <= 1'b1; r_kind <= TK_NONE;
            r_w     <= '0;       r_h    <= '0;  r_num  <= '0;   r_den  <= '0;
            r_rs    <= RS_NONE;  r_mode <= MODE_NONE; r_fnum <= '0; r_fmt <= FMT_420;
        end else if (i_accept) begin
            r_phase <= n_phase; r_midx <= n_midx; r_good <= n_good; r_kind <= n_kind;
            r_w     <= n_w;     r_h    <= n_h;    r_num  <= n_num;  r_den  <= n_den;
            r_rs    <= n_rs;    r_mode <= n_mode; r_fnum <= n_fnum; r_fmt  <= n_fmt;
        end
    end

    // header contents as seen by a newline arriving now
    always_comb begin
        o_snap.ok     = (c_phase != PH_MAGIC) && (c_phase != PH_SKIP) && c_good;
        o_snap.width  = c_w;
        o_snap.height = c_h;
        o_snap.num    = c_num;
        o_snap.den    = c_den;
        o_snap.err    = (c_rs == RS_BEGUN) || ((c_rs == RS_DEN) && (c_den == '0));
        o_snap.do_div = (c_rs == RS_DEN) && (c_den != '0);
        o_snap.mode   = c_mode;
        o_snap.fmt    = ((c_phase == PH_TOKEN) && commit_ok) ? fmt_code : c_fmt;
    end

endmodule

`default_nettype wire

### design/y4m_dp.sv
// Result datapath: job registers, bit-serial divider, frame size and output register.
`default_nettype none

module y4m_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire y4m_pkg::t_snap                  i_snap,
    input  wire y4m_pkg::t_ctrl_cmd              i_cmd,
    output y4m_pkg::t_dp_stat                    o_stat,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_header_ok,
    output logic [y4m_pkg::DIM_BITS-1:0]         o_width,
    output logic [y4m_pkg::DIM_BITS-1:0]         o_height,
    output logic [y4m_pkg::RATE_BITS-1:0]        o_fps,
    output logic                                 o_rate_error,
    output logic [2:0]                           o_scan_mode,
    output logic [1:0]                           o_chroma_format,
    output logic [y4m_pkg::FB_BITS-1:0]          o_frame_bytes
);
    import y4m_pkg::*;

    logic                  r_ok, r_err, r_do_div;
    logic [DIM_BITS-1:0]   r_w, r_h;
    logic [RATE_BITS-1:0]  r_den;
    logic [RATE_BITS-1:0]  r_q;
    logic [RATE_BITS-1:0]  r_rem;
    logic [2:0]            r_mode;
    logic [1:0]            r_fmt;
    logic [PX_BITS-1:0]    r_px;
    logic                  r_out_valid, n_out_valid;

    logic [RATE_BITS:0]    rem_sh;
    logic [RATE_BITS:0]    rem_sub;
    logic [FB_BITS-1:0]    px3;
    logic [FB_BITS-1:0]    fb;

    // restoring division, one quotient bit per step
    assign rem_sh  = {r_rem, r_q[RATE_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ok     <= i_snap.ok;
            r_w      <= i_snap.width;
            r_h      <= i_snap.height;
            r_den    <= i_snap.den;
            r_err    <= i_snap.err;
            r_do_div <= i_snap.do_div;
            r_mode   <= i_snap.mode;
            r_fmt    <= i_snap.fmt;
            r_q      <= i_snap.num;
            r_rem    <= '0;
            r_px     <= PX_BITS'(i_snap.width) * PX_BITS'(i_snap.height);
        end else if (i_cmd.div_step) begin
            if (!rem_sub[RATE_BITS]) begin
                r_rem <= rem_sub[RATE_BITS-1:0];
                r_q   <= {r_q[RATE_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[RATE_BITS-1:0];
                r_q   <= {r_q[RATE_BITS-2:0], 1'b0};
            end
        end
    end

    assign px3 = FB_BITS'(r_px) + (FB_BITS'(r_px) << 1);

    always_comb begin
        unique case (r_fmt)
            FMT_422: fb = FB_BITS'(r_px) << 1;
            FMT_444: fb = px3;
            FMT_420: fb = px3 >> 1;
            FMT_411: fb = px3 >> 1;
            default: fb = px3 >> 1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_header_ok     <= r_ok;
            o_width         <= r_w;
            o_height        <= r_h;
            o_fps           <= r_do_div ? r_q : '0;
            o_rate_error    <= r_err;
            o_scan_mode     <= r_mode;
            o_chroma_format <= r_fmt;
            o_frame_bytes   <= fb;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_load)          n_out_valid = 1'b1;
        else if (r_out_valid && !i_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else          r_out_valid <= n_out_valid;
    end

    assign o_valid         = r_out_valid;
    assign o_stat.out_free = !r_out_valid || !i_stall;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result loaded over an untaken item");

    a_err_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rate_error && (o_fps != '0)))
        else $error("frame rate given with a rate error");

    a_bad_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_header_ok) |-> ((o_width == '0) && (o_height == '0)
                                       && (o_frame_bytes == '0)))
        else $error("fields parsed from a rejected header");

    a_no_cmd_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.div_step))
        else $error("load and divide step together");

endmodule

`default_nettype wire

### design/y4m_ctrl.sv
// Job controller: sequences load, divide steps and result hand-off.
`default_nettype none

module y4m_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_launch,
    input  wire y4m_pkg::t_dp_stat   i_stat,
    output y4m_pkg::t_ctrl_cmd       o_cmd,
    output logic                     o_idle
);
    import y4m_pkg::*;

    t_state                  r_state, n_state;
    logic [DIV_CNT_BITS-1:0] r_cnt,   n_cnt;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_launch) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(RATE_BITS - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load) |=> (r_state == ST_DIV) && (r_cnt == '0))
        else $error("job load did not start the divider");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_cnt != DIV_CNT_BITS'(RATE_BITS - 1)))
        |=> (r_state == ST_DIV))
        else $error("divider left early");

endmodule

`default_nettype wire

### verif/y4m_stream_header_parser_unit_tb.sv
// Self-checking testbench for the YUV4MPEG2 header parser: directed headers, then random ones.
module y4m_stream_header_parser_unit_tb;
    import y4m_pkg::*;

    // One parsed header as it should leave the result channel.
    typedef struct {
        bit                 ok;
        bit [DIM_BITS-1:0]  width;
        bit [DIM_BITS-1:0]  height;
        bit [RATE_BITS-1:0] rate;
        bit                 rate_err;
        bit [2:0]           mode;
        bit [1:0]           fmt;
        bit [FB_BITS-1:0]   fbytes;
    } t_hdr_info;

    // Directed row: header text, start flag on its first byte, and an optional hand-typed answer.
    typedef struct {
        string     txt;
        bit        start;
        bit        typed;
        t_hdr_info want;
    } t_hdr_row;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  hdr_valid = 1'b0;
    logic                  hdr_stall;
    logic [7:0]            hdr_byte  = 8'h00;
    logic                  hdr_start = 1'b0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic                  res_ok;
    logic [DIM_BITS-1:0]   res_width;
    logic [DIM_BITS-1:0]   res_height;
    logic [RATE_BITS-1:0]  res_rate;
    logic                  res_rate_err;
    logic [2:0]            res_mode;
    logic [1:0]            res_fmt;
    logic [FB_BITS-1:0]    res_fbytes;

    t_hdr_info   expected_hdrs[$];
    logic [7:0]  pend[$];
    string       magic_text = "YUV4MPEG2";
    int unsigned n_fail     = 0;
    int unsigned n_items    = 0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_style = 0;

    // Parser shadow state.
    t_phase               ph;
    int unsigned          mag_idx;
    bit                   mag_good;
    t_token               tok;
    bit [DIM_BITS-1:0]    w_acc;
    bit [DIM_BITS-1:0]    h_acc;
    bit [RATE_BITS-1:0]   num_acc;
    bit [RATE_BITS-1:0]   den_acc;
    bit [1:0]             rate_prog;
    bit [2:0]             mode_r;
    bit [FMT_BITS-1:0]    fmt_acc;
    bit [1:0]             fmt_r;

    t_hdr_row dir_rows [0:15] = '{
        '{"YUV4MPEG2 \n", 1'b1, 1'b1,
          '{1'b1, 16'd0, 16'd0, 32'd0, 1'b0, MODE_NONE, FMT_420, 34'd0}},
        '{"YUV4MPEG2 W1920 H1080 F30000:1001 Ip A1:1 C420jpeg\n", 1'b0, 1'b0, '{default: 0}},
        '{"YUV4MPEGX W10 H10\n", 1'b0, 1'b1,
          '{1'b0, 16'd0, 16'd0, 32'd0, 1'b0, MODE_NONE, FMT_420, 34'd0}},
        '{"YUV\n", 1'b0, 1'b1,
          '{1'b0, 16'd0, 16'd0, 32'd0, 1'b0, MODE_NONE, FMT_420, 34'd0}},
        '{"YUV4MPEG2 W99999 H70000 C444\n", 1'b0, 1'b1,
          '{1'b1, DIM_MAX, DIM_MAX, 32'd0, 1'b0, MODE_NONE, FMT_444, 34'd12884508675}},
        '{"YUV4MPEG2 F30:0\n", 1'b0, 1'b1,
          '{1'b1, 16'd0, 16'd0, 32'd0, 1'b1, MODE_NONE, FMT_420, 34'd0}},
        '{"YUV4MPEG2 F:1 It\n", 1'b0, 1'b0, '{default: 0}},
        '{"YUV4MPEG2  F25   Ib  C422\n", 1'b0, 1'b0, '{default: 0}},
        '{"YUV4MPEG2\n", 1'b0, 1'b0, '{default: 0}},
        '{"YUV4MPEG2 W64 H48 F99999999999:1 Im C411\n", 1'b0, 1'b0, '{default: 0}},
        '{"YUV4MPEG2 W8 W16 C999 C5000 C I Ix Iq\n", 1'b0, 1'b0, '{default: 0}},
        '{"YUV4MPEG2 W77 H33", 1'b0, 1'b0, '{default: 0}},
        '{"YUV4MPEG2 H5 F1:99999999999 Cx Ip\n", 1'b1, 1'b0, '{default: 0}},
        '{"\n", 1'b0, 1'b1,
          '{1'b0, 16'd0, 16'd0, 32'd0, 1'b0, MODE_NONE, FMT_420, 34'd0}},
        '{"YUV4MPEG2 W-5 H 7 F30:\n", 1'b0, 1'b0, '{default: 0}},
        '{"YUV4MPEG2 W65535 H65535 C422 F60:1\n", 1'b0, 1'b0, '{default: 0}}
    };

    y4m_stream_header_parser_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (hdr_valid),
        .o_stall         (hdr_stall),
        .i_data_byte     (hdr_byte),
        .i_start_req     (hdr_start),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_header_ok     (res_ok),
        .o_width         (res_width),
        .o_height        (res_height),
        .o_fps           (res_rate),
        .o_rate_error    (res_rate_err),
        .o_scan_mode     (res_mode),
        .o_chroma_format (res_fmt),
        .o_frame_bytes   (res_fbytes)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // Append one decimal digit, clamping at the given ceiling.
    function automatic longint unsigned dec_push(longint unsigned acc, logic [7:0] ch,
                                                 longint unsigned lim);
        longint unsigned v;
        v = acc * 10 + (ch - CH_ZERO);
        return (v > lim) ? lim : v;
    endfunction

    function automatic void clear_parse();
        ph        = PH_MAGIC;
        mag_idx   = 0;
        mag_good  = 1'b1;
        tok       = TK_NONE;
        w_acc     = '0;
        h_acc     = '0;
        num_acc   = '0;
        den_acc   = '0;
        rate_prog = RS_NONE;
        mode_r    = MODE_NONE;
        fmt_acc   = '0;
        fmt_r     = FMT_420;
    endfunction

    // Only the four known chroma numbers move the format; anything else leaves it alone.
    function automatic void apply_chroma();
        if (tok == TK_C) begin
            case (fmt_acc)
                10'd420: fmt_r = FMT_420;
                10'd422: fmt_r = FMT_422;
                10'd444: fmt_r = FMT_444;
                10'd411: fmt_r = FMT_411;
                default: ;
            endcase
        end
    endfunction

    function automatic void begin_token(logic [7:0] ch);
        ph = PH_TOKEN;
        case (ch)
            CH_W: begin
                w_acc = '0;
                tok   = TK_W;
            end
            CH_H: begin
                h_acc = '0;
                tok   = TK_H;
            end
            CH_F: begin
                num_acc   = '0;
                den_acc   = '0;
                rate_prog = RS_BEGUN;
                tok       = TK_FBEG;
            end
            CH_I: begin
                mode_r = MODE_UNKNOWN;
                tok    = TK_I;
            end
            CH_C: begin
                fmt_acc = '0;
                tok     = TK_C;
            end
            default: tok = TK_NONE;
        endcase
    endfunction

    function automatic void token_char(logic [7:0] ch);
        bit is_dig;
        is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
        case (tok)
            TK_W: begin
                if (is_dig) w_acc = DIM_BITS'(dec_push(64'(w_acc), ch, 64'(DIM_MAX)));
                else tok = TK_NONE;
            end
            TK_H: begin
                if (is_dig) h_acc = DIM_BITS'(dec_push(64'(h_acc), ch, 64'(DIM_MAX)));
                else tok = TK_NONE;
            end
            TK_FBEG: begin
                if (is_dig) begin
                    num_acc = RATE_BITS'(ch - CH_ZERO);
                    tok     = TK_FNUM;
                end else begin
                    tok = TK_NONE;
                end
            end
            TK_FNUM: begin
                if (is_dig) num_acc = RATE_BITS'(dec_push(64'(num_acc), ch, 64'(RATE_MAX)));
                else if (ch == CH_COLON) tok = TK_FDEN;
                else tok = TK_NONE;
            end
            TK_FDEN: begin
                if (is_dig) begin
                    den_acc   = RATE_BITS'(dec_push(64'(den_acc), ch, 64'(RATE_MAX)));
                    rate_prog = RS_DEN;
                end else begin
                    tok = TK_NONE;
                end
            end
            TK_I: begin
                case (ch)
                    CH_P:    mode_r = MODE_PROG;
                    CH_T:    mode_r = MODE_TOP;
                    CH_B:    mode_r = MODE_BOTTOM;
                    CH_M:    mode_r = MODE_MIXED;
                    default: mode_r = MODE_UNKNOWN;
                endcase
                tok = TK_NONE;
            end
            TK_C: begin
                if (is_dig) begin
                    fmt_acc = FMT_BITS'(dec_push(64'(fmt_acc), ch, 64'(FMT_MAX)));
                end else begin
                    apply_chroma();
                    tok = TK_NONE;
                end
            end
            default: ;
        endcase
    endfunction

    // Advance the shadow parser by one accepted byte; a newline yields the header it closes.
    function automatic void predict_header_byte(input logic [7:0] ch, input bit st,
                                                output bit emit, output t_hdr_info r);
        longint unsigned px;
        longint unsigned fb;
        r    = '{default: 0};
        emit = 1'b0;
        if (st) clear_parse();
        if (ch == CH_NL) begin
            r.ok = (ph != PH_MAGIC) && (ph != PH_SKIP) && mag_good;
            if (ph == PH_TOKEN) apply_chroma();
            if (rate_prog == RS_BEGUN) begin
                r.rate_err = 1'b1;
            end else if (rate_prog == RS_DEN) begin
                if (den_acc == 0) r.rate_err = 1'b1;
                else r.rate = num_acc / den_acc;
            end
            px = longint'(w_acc) * longint'(h_acc);
            case (fmt_r)
                FMT_422: fb = px * 2;
                FMT_444: fb = px * 3;
                default: fb = (px * 3) / 2;
            endcase
            r.width  = w_acc;
            r.height = h_acc;
            r.mode   = mode_r;
            r.fmt    = fmt_r;
            r.fbytes = fb[FB_BITS-1:0];
            emit     = 1'b1;
            clear_parse();
            return;
        end
        case (ph)
            PH_MAGIC: begin
                if (mag_idx < MAGIC_LEN && ch != magic_text[mag_idx]) mag_good = 1'b0;
                mag_idx++;
                if (mag_idx >= MAGIC_LEN) begin
                    if (mag_good) ph = PH_SEP;
                    else ph = PH_SKIP;
                end
            end
            PH_SEP: ph = PH_GAP;
            PH_GAP: begin
                if (ch != CH_SPACE) begin_token(ch);
            end
            PH_TOKEN: begin
                if (ch == CH_SPACE) begin
                    apply_chroma();
                    tok = TK_NONE;
                    ph  = PH_GAP;
                end else begin
                    token_char(ch);
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- header composer

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++) pend.push_back(s[k]);
    endfunction

    // Mostly short numbers; now and then long enough to saturate.
    function automatic void push_digits();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        repeat (n) pend.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // Build one header into pend: mostly well formed, sometimes with broken magic,
    // cut short, or an odd separator.
    function automatic void compose_header();
        int unsigned ntok;
        int unsigned form;
        int unsigned keep;
        pend.delete();
        push_text(magic_text);
        if ($urandom_range(0, 11) == 0) begin
            pend[$urandom_range(0, MAGIC_LEN - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 29) == 0) begin
            keep = $urandom_range(0, MAGIC_LEN - 1);
            while (pend.size() > keep) void'(pend.pop_back());
            pend.push_back(CH_NL);
            return;
        end
        pend.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_SPACE);
        ntok = $urandom_range(0, 7);
        repeat (ntok) begin
            repeat ($urandom_range(1, 3)) pend.push_back(CH_SPACE);
            case ($urandom_range(0, 7))
                0: begin
                    pend.push_back(CH_W);
                    push_digits();
                end
                1: begin
                    pend.push_back(CH_H);
                    push_digits();
                end
                2: begin
                    // rate forms: n:d, n, n:, :d, n:0
                    pend.push_back(CH_F);
                    form = $urandom_range(0, 5);
                    if (form != 3) push_digits();
                    if (form != 1) pend.push_back(CH_COLON);
                    if (form == 4) pend.push_back(CH_ZERO);
                    else if (form == 0 || form == 3 || form == 5) push_digits();
                end
                3: begin
                    pend.push_back(CH_I);
                    case ($urandom_range(0, 5))
                        0: pend.push_back(CH_P);
                        1: pend.push_back(CH_T);
                        2: pend.push_back(CH_B);
                        3: pend.push_back(CH_M);
                        4: pend.push_back(8'($urandom_range(33, 126)));
                        default: ;
                    endcase
                end
                4: begin
                    pend.push_back(CH_C);
                    case ($urandom_range(0, 5))
                        0: push_text("420");
                        1: push_text("422");
                        2: push_text("444");
                        3: push_text("411");
                        4: push_digits();
                        default: ;
                    endcase
                    if ($urandom_range(0, 3) == 0) push_text("jpeg");
                end
                5: push_text("A1:1");
                default: repeat ($urandom_range(1, 4)) pend.push_back(8'($urandom_range(33, 126)));
            endcase
        end
        pend.push_back(CH_NL);
    endfunction

    // ---------------------------------------------------------------- byte sender

    // Offer one item, holding it until taken; the sender runs in bursts with idle gaps.
    task automatic send_byte(input logic [7:0] ch, input bit st,
                             output bit emit, output t_hdr_info r);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                hdr_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        hdr_valid <= 1'b1;
        hdr_byte  <= ch;
        hdr_start <= st;
        do @(posedge clk); while (hdr_stall);
        predict_header_byte(ch, st, emit, r);
        n_items++;
    endtask

    initial begin : stimulus
        bit          emit;
        t_hdr_info   r;
        int unsigned cut;
        clear_parse();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed headers: typed answers replace the prediction where the row has one.
        foreach (dir_rows[i]) begin
            for (int k = 0; k < dir_rows[i].txt.len(); k++) begin
                send_byte(dir_rows[i].txt[k], dir_rows[i].start && (k == 0), emit, r);
                if (emit) expected_hdrs.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
            end
        end

        // Random headers with a sprinkling of raw noise and abandoned headers.
        while (n_items < 1200) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, emit, r);
                    if (emit) expected_hdrs.push_back(r);
                end
            end else begin
                compose_header();
                cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, pend.size() - 1)
                                                   : pend.size();
                for (int k = 0; k < cut; k++) begin
                    send_byte(pend[k],
                              (k == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 199) == 0),
                              emit, r);
                    if (emit) expected_hdrs.push_back(r);
                end
            end
        end
        hdr_valid <= 1'b0;

        // Drain, then allow a full divider latency for anything spurious.
        while (expected_hdrs.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    // Stall style is redrawn whenever its countdown runs out: none, light random, heavy.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 2);
            stall_left  <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 1) == 1);
            default: res_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // Compare each taken result with the oldest pending header.
    always @(posedge clk) begin : result_check
        t_hdr_info want;
        if (rst_n && res_valid && !res_stall) begin
            if (expected_hdrs.size() == 0) begin
                $error("result with no header pending");
                n_fail++;
            end else begin
                want = expected_hdrs.pop_front();
                check_field("header_ok", 64'(want.ok), 64'(res_ok));
                check_field("width", 64'(want.width), 64'(res_width));
                check_field("height", 64'(want.height), 64'(res_height));
                check_field("fps", 64'(want.rate), 64'(res_rate));
                check_field("rate_error", 64'(want.rate_err), 64'(res_rate_err));
                check_field("scan_mode", 64'(want.mode), 64'(res_mode));
                check_field("chroma_format", 64'(want.fmt), 64'(res_fmt));
                check_field("frame_bytes", 64'(want.fbytes), 64'(res_fbytes));
            end
        end
    end

endmodule
